[rtl/sdr_pkg.sv]
`timescale 1ns / 1ps

package sdr_pkg;

   // Fixed field widths
   localparam int WORD_W    = 32;
   localparam int CFG_W     = 9;
   localparam int ROW_BITS  = 10;
   localparam int RCOL_BITS = 8;

   // Depth 1.0 in signed Q7.24
   localparam logic [WORD_W-1:0] DEPTH_ONE = 32'h0100_0000;

   // Transaction modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_FILL  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_ROW_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_SLICE_FIRST = 2'd1;
   localparam logic [1:0] CSR_SLICE_END   = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] RESET_ROW_WIDTH   = 9'd256;
   localparam logic [CFG_W-1:0] RESET_SLICE_FIRST = 9'd0;
   localparam logic [CFG_W-1:0] RESET_SLICE_END   = 9'd256;

   // Destination of a multiply-accumulate result
   typedef enum logic [1:0] {
      TAG_LX,
      TAG_LD,
      TAG_RX,
      TAG_SPAN
   } tag_type;

   typedef struct packed {
      logic              valid;
      tag_type           tag;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] n;
   } mac_req_type;

   typedef struct packed {
      logic              valid;
      tag_type           tag;
      logic [WORD_W-1:0] value;
   } mac_rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_READ_CAP,
      ST_ROW,
      ST_SPAN_WAIT,
      ST_SPAN,
      ST_STEP_LX,
      ST_STEP_LD,
      ST_STEP_RX,
      ST_STEP_WAIT,
      ST_DONE
   } state_type;

endpackage

[rtl/sdr_ram.sv]
`timescale 1ns / 1ps

module sdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sdr_mac.sv]
`timescale 1ns / 1ps

// a + b * n modulo 2^32, two stages, one operation may enter every cycle
module sdr_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  sdr_pkg::mac_req_type req,
   output sdr_pkg::mac_rsp_type rsp
);

   logic                               s1_valid_ff;
   sdr_pkg::tag_type                   s1_tag_ff;
   logic [sdr_pkg::WORD_W-1:0]         s1_base_ff;
   logic [sdr_pkg::WORD_W-1:0]         s1_prod_ff;
   logic [sdr_pkg::WORD_W-1:0]         s1_prod_in;
   logic                               s2_valid_ff;
   sdr_pkg::tag_type                   s2_tag_ff;
   logic [sdr_pkg::WORD_W-1:0]         s2_sum_ff;
   logic [sdr_pkg::WORD_W-1:0]         s2_sum_in;

   // low word of the product, then the accumulate
   assign s1_prod_in = sdr_pkg::WORD_W'(req.b * req.n);
   assign s2_sum_in  = s1_base_ff + s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff  <= req.tag;
      s1_base_ff <= req.a;
      s1_prod_ff <= s1_prod_in;
      s2_tag_ff  <= s1_tag_ff;
      s2_sum_ff  <= s2_sum_in;
   end

   assign rsp.valid = s2_valid_ff;
   assign rsp.tag   = s2_tag_ff;
   assign rsp.value = s2_sum_ff;

endmodule

[rtl/span_depth_rasterizer.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  mode, edges, steps, rows, read column
// rsp      out        rsp_valid/rsp_stall  advanced edges, read depth
// csr      in         csr_wr_en            csr_index, csr_wr_data
//
// After reset the whole buffer is wiped to 1.0 with req_stall high. Clear: the slice rows
// at the effective row width, one store write per cycle. Fill: a clipped top first steps
// the edges to the slice start; each row then has a row check and an edge step through the
// shared two-stage multiply-accumulate, and each drawn row also has its span pixels.
// Rows advanced above the slice cost one edge step in total.
// The next transaction is taken while a result still waits on a stalled rsp channel.
module span_depth_rasterizer #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int X_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_left_x,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_right_x,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_left_depth,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_left_x_step,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_right_x_step,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_left_depth_step,
   input  logic signed [sdr_pkg::WORD_W-1:0]     req_depth_per_pixel,
   input  logic signed [sdr_pkg::ROW_BITS-1:0]   req_top_row,
   input  logic signed [sdr_pkg::ROW_BITS-1:0]   req_bottom_row,
   input  logic [sdr_pkg::RCOL_BITS-1:0]         req_read_column,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sdr_pkg::WORD_W-1:0]     rsp_left_x_next,
   output logic signed [sdr_pkg::WORD_W-1:0]     rsp_left_depth_next,
   output logic signed [sdr_pkg::WORD_W-1:0]     rsp_right_x_next,
   output logic signed [sdr_pkg::WORD_W-1:0]     rsp_read_depth,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [sdr_pkg::CFG_W-1:0]             csr_wr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = COL_W + 1;
   // rows never exceed 511, so the buffer height only matters below that
   localparam int ROW_LIM = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;
   localparam int RW      = sdr_pkg::ROW_BITS;
   localparam int WW      = sdr_pkg::WORD_W;

   // Configuration registers
   logic [sdr_pkg::CFG_W-1:0] row_width_ff, row_width_in;
   logic [sdr_pkg::CFG_W-1:0] slice_first_ff, slice_first_in;
   logic [sdr_pkg::CFG_W-1:0] slice_end_ff, slice_end_in;

   // Sequencer state
   sdr_pkg::state_type state_ff, state_in;
   sdr_pkg::state_type step_ret_ff, step_ret_in;
   logic               step_inc_ff, step_inc_in;
   logic [WW-1:0]      lx_ff, lx_in, rx_ff, rx_in, ld_ff, ld_in;
   logic [WW-1:0]      lxs_ff, lxs_in, rxs_ff, rxs_in, lds_ff, lds_in, dpp_ff, dpp_in;
   logic [1:0]         mode_ff, mode_in;
   logic signed [RW-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [sdr_pkg::RCOL_BITS-1:0] rcol_ff, rcol_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]   col_ff, col_in, en_ff, en_in;
   logic [WW-1:0]      d_ff, d_in, step_n_ff, step_n_in, rd_ff, rd_in;
   logic [ADDR_W-1:0]  wipe_ff, wipe_in;

   // Pixel compare stage
   logic               pix_valid_ff, pix_valid_in;
   logic [ADDR_W-1:0]  pix_addr_ff, pix_addr_in;
   logic [WW-1:0]      pix_depth_ff, pix_depth_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic [WW-1:0]      rsp_lx_ff, rsp_ld_ff, rsp_rx_ff, rsp_rd_ff;

   // Store ports
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [WW-1:0]      ram_wr_data, ram_rd_data;

   // Shared multiply-accumulate
   sdr_pkg::mac_req_type mac_req;
   sdr_pkg::mac_rsp_type mac_rsp;

   // Derived values
   logic [CNT_W-1:0]   w_val;
   logic [RW-1:0]      clr_end;
   logic               clear_ok, read_ok;
   logic signed [11:0] top_s, bot_s, s0_s, s1_s, adv_n, clip_n;
   logic signed [32:0] xs_ext, xe_ext, w_ext, st_ext, en_ext, neg_xs;
   logic               span_ok;
   logic [WW-1:0]      span_n;
   logic [RW-1:0]      top_u;
   logic [ADDR_W-1:0]  span_addr, clear_addr, read_addr;

   // Effective width and clear extent
   assign w_val = (int'(row_width_ff) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(row_width_ff);
   assign clr_end = (int'(slice_end_ff) < ROW_LIM) ? {1'b0, slice_end_ff} : RW'(ROW_LIM);
   assign clear_ok = (w_val != '0) && ({1'b0, slice_first_ff} < clr_end);

   // Row bounds compared in 12-bit signed
   assign top_s  = {{2{top_ff[RW-1]}}, top_ff};
   assign bot_s  = {{2{bot_ff[RW-1]}}, bot_ff};
   assign s0_s   = {3'b000, slice_first_ff};
   assign s1_s   = {3'b000, slice_end_ff};
   assign adv_n  = bot_s - top_s;
   assign clip_n = s0_s - top_s;

   // Read position
   assign top_u     = top_ff;
   assign read_ok   = !top_ff[RW-1] && ({1'b0, top_u[RW-2:0]} < RW'(ROW_LIM))
                      && (int'(rcol_ff) < int'(w_val));
   assign read_addr = {ROW_W'(top_u), COL_W'(rcol_ff)};

   // Span columns of the current row
   assign xs_ext  = $signed({lx_ff[WW-1], lx_ff}) >>> X_FRAC_BITS;
   assign xe_ext  = $signed({rx_ff[WW-1], rx_ff}) >>> X_FRAC_BITS;
   assign w_ext   = $signed({{(33 - CNT_W){1'b0}}, w_val});
   assign st_ext  = xs_ext[32] ? '0 : xs_ext;
   assign en_ext  = (xe_ext < w_ext) ? xe_ext : w_ext;
   assign span_ok = st_ext < en_ext;
   assign neg_xs  = -xs_ext;
   assign span_n  = xs_ext[32] ? neg_xs[WW-1:0] : '0;

   assign span_addr  = {ROW_W'(row_ff), COL_W'(col_ff)};
   assign clear_addr = span_addr;

   // Configuration writes
   always_comb begin
      row_width_in   = row_width_ff;
      slice_first_in = slice_first_ff;
      slice_end_in   = slice_end_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sdr_pkg::CSR_ROW_WIDTH:   row_width_in   = csr_wr_data;
            sdr_pkg::CSR_SLICE_FIRST: slice_first_in = csr_wr_data;
            sdr_pkg::CSR_SLICE_END:   slice_end_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequencer: next state, store access and unit issue
   always_comb begin
      state_in     = state_ff;
      step_ret_in  = step_ret_ff;
      step_inc_in  = step_inc_ff;
      lx_in        = lx_ff;
      rx_in        = rx_ff;
      ld_in        = ld_ff;
      lxs_in       = lxs_ff;
      rxs_in       = rxs_ff;
      lds_in       = lds_ff;
      dpp_in       = dpp_ff;
      mode_in      = mode_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      rcol_in      = rcol_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      en_in        = en_ff;
      d_in         = d_ff;
      step_n_in    = step_n_ff;
      rd_in        = rd_ff;
      wipe_in      = wipe_ff;
      pix_valid_in = 1'b0;
      pix_addr_in  = pix_addr_ff;
      pix_depth_in = pix_depth_ff;
      rsp_load     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clear_addr;
      ram_wr_data  = sdr_pkg::DEPTH_ONE;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = span_addr;
      mac_req      = '0;

      unique case (state_ff)
         sdr_pkg::ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wipe_ff;
            wipe_in     = wipe_ff + 1'b1;
            if (wipe_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = sdr_pkg::ST_IDLE;
            end
         end

         sdr_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               lx_in    = req_left_x;
               rx_in    = req_right_x;
               ld_in    = req_left_depth;
               lxs_in   = req_left_x_step;
               rxs_in   = req_right_x_step;
               lds_in   = req_left_depth_step;
               dpp_in   = req_depth_per_pixel;
               top_in   = req_top_row;
               bot_in   = req_bottom_row;
               rcol_in  = req_read_column;
               rd_in    = '0;
               state_in = sdr_pkg::ST_DECODE;
            end
         end

         sdr_pkg::ST_DECODE: begin
            if (mode_ff == sdr_pkg::MODE_CLEAR) begin
               row_in   = {1'b0, slice_first_ff};
               col_in   = '0;
               state_in = clear_ok ? sdr_pkg::ST_CLEAR : sdr_pkg::ST_DONE;
            end else if (mode_ff == sdr_pkg::MODE_READ) begin
               if (read_ok) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = read_addr;
                  state_in    = sdr_pkg::ST_READ_CAP;
               end else begin
                  state_in = sdr_pkg::ST_DONE;
               end
            end else if (mode_ff == sdr_pkg::MODE_FILL && top_s < s1_s && top_s != bot_s) begin
               if (bot_s <= s0_s) begin
                  // wholly above the slice: advance the edges only
                  step_n_in   = {{(WW - 12){adv_n[11]}}, adv_n};
                  step_ret_in = sdr_pkg::ST_DONE;
                  step_inc_in = 1'b0;
                  state_in    = sdr_pkg::ST_STEP_LX;
               end else begin
                  if (bot_s > s1_s) begin
                     bot_in = RW'(s1_s);
                  end
                  if (top_s < s0_s) begin
                     // clip the top to the slice start
                     row_in      = {1'b0, slice_first_ff};
                     step_n_in   = {{(WW - 12){clip_n[11]}}, clip_n};
                     step_ret_in = sdr_pkg::ST_ROW;
                     step_inc_in = 1'b0;
                     state_in    = sdr_pkg::ST_STEP_LX;
                  end else begin
                     row_in   = top_u;
                     state_in = sdr_pkg::ST_ROW;
                  end
               end
            end else begin
               state_in = sdr_pkg::ST_DONE;
            end
         end

         sdr_pkg::ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (CNT_W'(col_ff + 1'b1) == w_val) begin
               col_in = '0;
               if (RW'(row_ff + 1'b1) == clr_end) begin
                  state_in = sdr_pkg::ST_DONE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         sdr_pkg::ST_READ_CAP: begin
            rd_in    = ram_rd_data;
            state_in = sdr_pkg::ST_DONE;
         end

         sdr_pkg::ST_ROW: begin
            if (row_ff >= $unsigned(bot_ff)) begin
               state_in = sdr_pkg::ST_DONE;
            end else if (row_ff < RW'(ROW_LIM) && span_ok) begin
               // start depth at the first drawn column
               mac_req.valid = 1'b1;
               mac_req.tag   = sdr_pkg::TAG_SPAN;
               mac_req.a     = ld_ff;
               mac_req.b     = dpp_ff;
               mac_req.n     = span_n;
               col_in        = st_ext[CNT_W-1:0];
               en_in         = en_ext[CNT_W-1:0];
               state_in      = sdr_pkg::ST_SPAN_WAIT;
            end else begin
               step_n_in   = WW'(1);
               step_ret_in = sdr_pkg::ST_ROW;
               step_inc_in = 1'b1;
               state_in    = sdr_pkg::ST_STEP_LX;
            end
         end

         sdr_pkg::ST_SPAN_WAIT: begin
            if (mac_rsp.valid) begin
               state_in = sdr_pkg::ST_SPAN;
            end
         end

         sdr_pkg::ST_SPAN: begin
            // read one pixel; it is compared and written in the next cycle
            ram_rd_en    = 1'b1;
            pix_valid_in = 1'b1;
            pix_addr_in  = span_addr;
            pix_depth_in = d_ff;
            d_in         = d_ff + dpp_ff;
            col_in       = col_ff + 1'b1;
            if (CNT_W'(col_ff + 1'b1) == en_ff) begin
               step_n_in   = WW'(1);
               step_ret_in = sdr_pkg::ST_ROW;
               step_inc_in = 1'b1;
               state_in    = sdr_pkg::ST_STEP_LX;
            end
         end

         sdr_pkg::ST_STEP_LX: begin
            mac_req.valid = 1'b1;
            mac_req.tag   = sdr_pkg::TAG_LX;
            mac_req.a     = lx_ff;
            mac_req.b     = lxs_ff;
            mac_req.n     = step_n_ff;
            state_in      = sdr_pkg::ST_STEP_LD;
         end

         sdr_pkg::ST_STEP_LD: begin
            mac_req.valid = 1'b1;
            mac_req.tag   = sdr_pkg::TAG_LD;
            mac_req.a     = ld_ff;
            mac_req.b     = lds_ff;
            mac_req.n     = step_n_ff;
            state_in      = sdr_pkg::ST_STEP_RX;
         end

         sdr_pkg::ST_STEP_RX: begin
            mac_req.valid = 1'b1;
            mac_req.tag   = sdr_pkg::TAG_RX;
            mac_req.a     = rx_ff;
            mac_req.b     = rxs_ff;
            mac_req.n     = step_n_ff;
            state_in      = sdr_pkg::ST_STEP_WAIT;
         end

         sdr_pkg::ST_STEP_WAIT: begin
            // right edge is issued last, so its result closes the step
            if (mac_rsp.valid && mac_rsp.tag == sdr_pkg::TAG_RX) begin
               state_in = step_ret_ff;
               if (step_inc_ff) begin
                  row_in = row_ff + 1'b1;
               end
            end
         end

         sdr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = sdr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sdr_pkg::ST_IDLE;
         end
      endcase

      // keep the smaller depth
      if (pix_valid_ff && ($signed(pix_depth_ff) < $signed(ram_rd_data))) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pix_addr_ff;
         ram_wr_data = pix_depth_ff;
      end

      // unit results land in their registers
      if (mac_rsp.valid) begin
         unique case (mac_rsp.tag)
            sdr_pkg::TAG_LX:   lx_in = mac_rsp.value;
            sdr_pkg::TAG_LD:   ld_in = mac_rsp.value;
            sdr_pkg::TAG_RX:   rx_in = mac_rsp.value;
            sdr_pkg::TAG_SPAN: d_in  = mac_rsp.value;
         endcase
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sdr_pkg::ST_INIT;
         wipe_ff        <= '0;
         pix_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         row_width_ff   <= sdr_pkg::RESET_ROW_WIDTH;
         slice_first_ff <= sdr_pkg::RESET_SLICE_FIRST;
         slice_end_ff   <= sdr_pkg::RESET_SLICE_END;
      end else begin
         state_ff       <= state_in;
         wipe_ff        <= wipe_in;
         pix_valid_ff   <= pix_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_width_ff   <= row_width_in;
         slice_first_ff <= slice_first_in;
         slice_end_ff   <= slice_end_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ret_ff  <= step_ret_in;
      step_inc_ff  <= step_inc_in;
      lx_ff        <= lx_in;
      rx_ff        <= rx_in;
      ld_ff        <= ld_in;
      lxs_ff       <= lxs_in;
      rxs_ff       <= rxs_in;
      lds_ff       <= lds_in;
      dpp_ff       <= dpp_in;
      mode_ff      <= mode_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      rcol_ff      <= rcol_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      en_ff        <= en_in;
      d_ff         <= d_in;
      step_n_ff    <= step_n_in;
      rd_ff        <= rd_in;
      pix_addr_ff  <= pix_addr_in;
      pix_depth_ff <= pix_depth_in;
      if (rsp_load) begin
         rsp_lx_ff <= lx_ff;
         rsp_ld_ff <= ld_ff;
         rsp_rx_ff <= rx_ff;
         rsp_rd_ff <= rd_ff;
      end
   end

   sdr_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   sdr_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_depth_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall           = (state_ff != sdr_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_x_next     = rsp_lx_ff;
   assign rsp_left_depth_next = rsp_ld_ff;
   assign rsp_right_x_next    = rsp_rx_ff;
   assign rsp_read_depth      = rsp_rd_ff;

endmodule

[rtl/sdr_checker.sv]
`timescale 1ns / 1ps

module sdr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [sdr_pkg::WORD_W-1:0]   rsp_left_x_next,
   input logic signed [sdr_pkg::WORD_W-1:0]   rsp_left_depth_next,
   input logic signed [sdr_pkg::WORD_W-1:0]   rsp_right_x_next,
   input logic signed [sdr_pkg::WORD_W-1:0]   rsp_read_depth
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_left_x_next) && $stable(rsp_left_depth_next)
         && $stable(rsp_right_x_next) && $stable(rsp_read_depth))
      else $error("rsp payload changed while stalled");

   // one transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken again without processing");

   // the buffer wipe holds off requests and no result is pending after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind span_depth_rasterizer sdr_checker u_sdr_checker (.*);

[verif/span_depth_rasterizer_tb.sv]
`timescale 1ns / 1ps

module span_depth_rasterizer_tb;

   localparam int MAX_W        = 256;
   localparam int MAX_H        = 256;
   localparam int X_FRAC       = 16;
   localparam int ROW_LO       = -16;
   localparam int ROW_HI       = 271;
   localparam int MAX_WAIT     = 13;
   localparam int REPORT_LIMIT = 10;
   localparam int STALL_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int CLEAR_BUDGET = 4096;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [31:0] PX = 32'h0001_0000;

   typedef struct {
      logic [1:0]        mode;
      logic [31:0]       left_x;
      logic [31:0]       right_x;
      logic [31:0]       left_depth;
      logic [31:0]       left_x_step;
      logic [31:0]       right_x_step;
      logic [31:0]       left_depth_step;
      logic [31:0]       depth_per_pixel;
      logic signed [9:0] top_row;
      logic signed [9:0] bottom_row;
      logic [7:0]        read_column;
   } span_request_type;

   typedef struct {
      logic [31:0] left_x_next;
      logic [31:0] left_depth_next;
      logic [31:0] right_x_next;
      logic [31:0] read_depth;
   } edge_result_type;

   // Depth buffer mirror, register copy and the queue of outstanding results
   class depth_scoreboard;
      bit [31:0]       depth_mem [MAX_W*MAX_H];
      int              width_px;
      int              first_row;
      int              end_row;
      edge_result_type expected_edges [$];
      int              mismatches;

      function new();
         foreach (depth_mem[i]) depth_mem[i] = sdr_pkg::DEPTH_ONE;
         width_px   = int'(sdr_pkg::RESET_ROW_WIDTH);
         first_row  = int'(sdr_pkg::RESET_SLICE_FIRST);
         end_row    = int'(sdr_pkg::RESET_SLICE_END);
         mismatches = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [sdr_pkg::CFG_W-1:0] value);
         case (index)
            sdr_pkg::CSR_ROW_WIDTH: begin
               width_px = int'(value);
            end
            sdr_pkg::CSR_SLICE_FIRST: begin
               first_row = int'(value);
            end
            sdr_pkg::CSR_SLICE_END: begin
               end_row = int'(value);
            end
            default: ;
         endcase
      endfunction

      function int visible_width();
         return width_px > MAX_W ? MAX_W : width_px;
      endfunction

      // base + delta * count, wrapping at 32 bits
      function bit [31:0] advance(bit [31:0] base, bit [31:0] delta, int count);
         bit [31:0] cnt;
         cnt = count;
         return base + delta * cnt;
      endfunction

      // Work out the result of one accepted transaction and update the buffer
      function void apply_request(span_request_type q);
         edge_result_type res;
         int top, bottom, s0, s1, w, row, col, xs, xe, st, en, stop;
         bit [31:0] lx, ld, rx, d;
         lx = q.left_x;
         ld = q.left_depth;
         rx = q.right_x;
         top = q.top_row;
         bottom = q.bottom_row;
         s0 = first_row;
         s1 = end_row;
         w = visible_width();
         res.read_depth = '0;
         case (q.mode)
            sdr_pkg::MODE_CLEAR: begin
               stop = s1 < MAX_H ? s1 : MAX_H;
               for (row = s0; row < stop; row++)
                  for (col = 0; col < w; col++)
                     depth_mem[row*MAX_W + col] = sdr_pkg::DEPTH_ONE;
            end
            sdr_pkg::MODE_READ: begin
               if (top >= 0 && top < MAX_H && q.read_column < w)
                  res.read_depth = depth_mem[top*MAX_W + q.read_column];
            end
            sdr_pkg::MODE_FILL: begin
               if (top < s1 && top != bottom) begin
                  if (bottom <= s0) begin
                     // wholly above the slice: edges only move
                     lx = advance(lx, q.left_x_step, bottom - top);
                     ld = advance(ld, q.left_depth_step, bottom - top);
                     rx = advance(rx, q.right_x_step, bottom - top);
                  end else begin
                     if (top < s0) begin
                        lx = advance(lx, q.left_x_step, s0 - top);
                        ld = advance(ld, q.left_depth_step, s0 - top);
                        rx = advance(rx, q.right_x_step, s0 - top);
                        top = s0;
                     end
                     if (bottom > s1) bottom = s1;
                     for (row = top; row < bottom; row++) begin
                        if (row >= 0 && row < MAX_H) begin
                           xs = $signed(lx) >>> X_FRAC;
                           xe = $signed(rx) >>> X_FRAC;
                           st = xs > 0 ? xs : 0;
                           en = xe < w ? xe : w;
                           if (st < en) begin
                              d = advance(ld, q.depth_per_pixel, st - xs);
                              for (col = st; col < en; col++) begin
                                 if ($signed(d) < $signed(depth_mem[row*MAX_W + col]))
                                    depth_mem[row*MAX_W + col] = d;
                                 d = d + q.depth_per_pixel;
                              end
                           end
                        end
                        lx = lx + q.left_x_step;
                        ld = ld + q.left_depth_step;
                        rx = rx + q.right_x_step;
                     end
                  end
               end
            end
            default: ;
         endcase
         res.left_x_next = lx;
         res.left_depth_next = ld;
         res.right_x_next = rx;
         expected_edges = {expected_edges, res};
      endfunction

      function void flag(string what, bit [31:0] want, bit [31:0] got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      endfunction

      function void check_result(edge_result_type got);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with no transaction outstanding", $time);
            return;
         end
         want = expected_edges.pop_front();
         if (got.left_x_next !== want.left_x_next)
            flag("left_x_next", want.left_x_next, got.left_x_next);
         if (got.left_depth_next !== want.left_depth_next)
            flag("left_depth_next", want.left_depth_next, got.left_depth_next);
         if (got.right_x_next !== want.right_x_next)
            flag("right_x_next", want.right_x_next, got.right_x_next);
         if (got.read_depth !== want.read_depth)
            flag("read_depth", want.read_depth, got.read_depth);
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_mode = '0;
   logic [31:0]               req_left_x = '0;
   logic [31:0]               req_right_x = '0;
   logic [31:0]               req_left_depth = '0;
   logic [31:0]               req_left_x_step = '0;
   logic [31:0]               req_right_x_step = '0;
   logic [31:0]               req_left_depth_step = '0;
   logic [31:0]               req_depth_per_pixel = '0;
   logic [9:0]                req_top_row = '0;
   logic [9:0]                req_bottom_row = '0;
   logic [7:0]                req_read_column = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [31:0]               rsp_left_x_next;
   logic [31:0]               rsp_left_depth_next;
   logic [31:0]               rsp_right_x_next;
   logic [31:0]               rsp_read_depth;
   logic                      csr_wr_en = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [sdr_pkg::CFG_W-1:0] csr_wr_data = '0;

   depth_scoreboard depth_sb;
   int idle_cycles = 0;
   int send_run_left = 0;
   int take_run_left = 0;
   bit send_quiet;
   bit take_quiet;

   span_depth_rasterizer #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H),
      .X_FRAC_BITS(X_FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_left_x(req_left_x),
      .req_right_x(req_right_x),
      .req_left_depth(req_left_depth),
      .req_left_x_step(req_left_x_step),
      .req_right_x_step(req_right_x_step),
      .req_left_depth_step(req_left_depth_step),
      .req_depth_per_pixel(req_depth_per_pixel),
      .req_top_row(req_top_row),
      .req_bottom_row(req_bottom_row),
      .req_read_column(req_read_column),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_x_next(rsp_left_x_next),
      .rsp_left_depth_next(rsp_left_depth_next),
      .rsp_right_x_next(rsp_right_x_next),
      .rsp_read_depth(rsp_read_depth),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Wait draw: runs of busy items mix at random with runs of no waiting at all
   function automatic int draw_wait(ref int run_left, ref bit run_quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(5, 30);
         run_quiet = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return run_quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   function automatic int clamp_row(int r);
      return r < ROW_LO ? ROW_LO : (r > ROW_HI ? ROW_HI : r);
   endfunction

   function automatic span_request_type make_req(logic [1:0] mode,
                                                 logic [31:0] lx, rx, ld, lxs, rxs, lds, dpp,
                                                 int top, bottom, col);
      span_request_type q;
      q.mode = mode;
      q.left_x = lx;
      q.right_x = rx;
      q.left_depth = ld;
      q.left_x_step = lxs;
      q.right_x_step = rxs;
      q.left_depth_step = lds;
      q.depth_per_pixel = dpp;
      q.top_row = 10'(top);
      q.bottom_row = 10'(bottom);
      q.read_column = 8'(col);
      return q;
   endfunction

   // Mostly well-formed trapezoids around the slice, plus reads, clears and noise
   function automatic span_request_type random_request();
      span_request_type q;
      int w, s0, s1, lo, hi, top, bottom, col, span, clear_rows, pick;
      w = depth_sb.visible_width();
      s0 = depth_sb.first_row;
      s1 = depth_sb.end_row;
      q.mode = sdr_pkg::MODE_FILL;
      q.left_x = $urandom;
      q.right_x = $urandom;
      q.left_depth = $urandom;
      q.left_x_step = $urandom;
      q.right_x_step = $urandom;
      q.left_depth_step = $urandom;
      q.depth_per_pixel = $urandom;
      q.read_column = 8'($urandom_range(0, 255));
      top = ROW_LO + int'($urandom_range(0, ROW_HI - ROW_LO));
      bottom = top + int'($urandom_range(0, 8)) - 2;
      lo = clamp_row((s0 < s1 ? s0 : s1) - 6);
      hi = clamp_row((s0 > s1 ? s0 : s1) + 3);
      clear_rows = (s1 < MAX_H ? s1 : MAX_H) - s0;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         q.mode = MODE_UNUSED;
      end else if (pick < 6 && clear_rows * w <= CLEAR_BUDGET) begin
         q.mode = sdr_pkg::MODE_CLEAR;
      end else if (pick < 30) begin
         q.mode = sdr_pkg::MODE_READ;
         if ($urandom_range(0, 3) != 0) begin
            top = lo + int'($urandom_range(0, hi - lo));
            q.read_column = 8'($urandom_range(0, w + 7 > 255 ? 255 : w + 7));
         end
      end else if (pick >= 40) begin
         top = lo + int'($urandom_range(0, hi - lo));
         bottom = top + int'($urandom_range(0, 14)) - 2;
         if ($urandom_range(0, 24) == 0)
            bottom = ROW_LO + int'($urandom_range(0, ROW_HI - ROW_LO));
         col = int'($urandom_range(0, w + 16)) - 8;
         span = int'($urandom_range(0, w / 4 + 2)) - 2;
         q.left_x = {16'(col), 16'($urandom)};
         q.right_x = q.left_x + {16'(span), 16'($urandom)};
         q.left_depth = int'($urandom_range(0, 1 << 25)) - (1 << 23);
         q.left_x_step = int'($urandom_range(0, 1 << 19)) - (1 << 18);
         q.right_x_step = int'($urandom_range(0, 1 << 19)) - (1 << 18);
         q.left_depth_step = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         q.depth_per_pixel = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      end
      q.top_row = 10'(top);
      q.bottom_row = 10'(clamp_row(bottom));
      return q;
   endfunction

   task automatic send_request(span_request_type q);
      int gap;
      gap = draw_wait(send_run_left, send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode <= q.mode;
      req_left_x <= q.left_x;
      req_right_x <= q.right_x;
      req_left_depth <= q.left_depth;
      req_left_x_step <= q.left_x_step;
      req_right_x_step <= q.right_x_step;
      req_left_depth_step <= q.left_depth_step;
      req_depth_per_pixel <= q.depth_per_pixel;
      req_top_row <= q.top_row;
      req_bottom_row <= q.bottom_row;
      req_read_column <= q.read_column;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (depth_sb.expected_edges.size() != 0);
   endtask

   task automatic write_slice_config(int width, int slice_first, int slice_end);
      csr_wr_en <= 1'b1;
      csr_index <= sdr_pkg::CSR_ROW_WIDTH;
      csr_wr_data <= sdr_pkg::CFG_W'(width);
      @(posedge clock);
      csr_index <= sdr_pkg::CSR_SLICE_FIRST;
      csr_wr_data <= sdr_pkg::CFG_W'(slice_first);
      @(posedge clock);
      csr_index <= sdr_pkg::CSR_SLICE_END;
      csr_wr_data <= sdr_pkg::CFG_W'(slice_end);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      depth_sb.write_reg(sdr_pkg::CSR_ROW_WIDTH, sdr_pkg::CFG_W'(width));
      depth_sb.write_reg(sdr_pkg::CSR_SLICE_FIRST, sdr_pkg::CFG_W'(slice_first));
      depth_sb.write_reg(sdr_pkg::CSR_SLICE_END, sdr_pkg::CFG_W'(slice_end));
   endtask

   task automatic run_phase(int width, int slice_first, int slice_end, int count);
      wait_drained();
      write_slice_config(width, slice_first, slice_end);
      repeat (count) send_request(random_request());
   endtask

   // Result side: stall for a drawn number of cycles, then take one result
   initial begin
      int hold;
      forever begin
         hold = draw_wait(take_run_left, take_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Monitor both channels, check results, watch for a hang
   always @(posedge clock) begin
      span_request_type q;
      edge_result_type r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            q.mode = req_mode;
            q.left_x = req_left_x;
            q.right_x = req_right_x;
            q.left_depth = req_left_depth;
            q.left_x_step = req_left_x_step;
            q.right_x_step = req_right_x_step;
            q.left_depth_step = req_left_depth_step;
            q.depth_per_pixel = req_depth_per_pixel;
            q.top_row = req_top_row;
            q.bottom_row = req_bottom_row;
            q.read_column = req_read_column;
            depth_sb.apply_request(q);
         end
         if (rsp_valid && !rsp_stall) begin
            r.left_x_next = rsp_left_x_next;
            r.left_depth_next = rsp_left_depth_next;
            r.right_x_next = rsp_right_x_next;
            r.read_depth = rsp_read_depth;
            depth_sb.check_result(r);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("span_depth_rasterizer_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      depth_sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions at the reset configuration
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(sdr_pkg::MODE_FILL, 32'h0003_8000, 32'h0028_0000,
                            sdr_pkg::DEPTH_ONE >> 1,
                            PX, -PX, 32'h0001_0000, 32'h0000_1000, 2, 8, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 4, 0, 10));
      // far depth loses the compare everywhere
      send_request(make_req(sdr_pkg::MODE_FILL, 32'h0003_8000, 32'h0028_0000, 32'h7FFF_FFFF,
                            PX, -PX, 0, 0, 2, 8, 0));
      // most negative depth wins: compare is signed
      send_request(make_req(sdr_pkg::MODE_FILL, 0, 32'h0040_0000, 32'h8000_0000,
                            0, 0, 0, 1, 3, 5, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3, 0, 20));
      // degenerate and inverted trapezoids
      send_request(make_req(sdr_pkg::MODE_FILL, PX, 32'h0010_0000, 0, PX, PX, PX, PX, 5, 5, 0));
      send_request(make_req(sdr_pkg::MODE_FILL, PX, 32'h0010_0000, 0, PX, PX, PX, PX, 10, 4, 0));
      // columns hanging off both sides of the row
      send_request(make_req(sdr_pkg::MODE_FILL, 32'hFFEC_0000, 32'h012C_0000, 0,
                            PX, -PX, 0, 32'h0000_0100, 20, 23, 0));
      // rows above the buffer only move the edges; step wraps
      send_request(make_req(sdr_pkg::MODE_FILL, 0, 32'h0010_0000, 0, 32'h7FFF_FFFF, 0,
                            32'h8000_0000, 0, -16, 3, 0));
      // full-width span at the bottom, clipped at the slice end
      send_request(make_req(sdr_pkg::MODE_FILL, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0,
                            32'h8000_0000, 250, 271, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, -1, 0, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, -16, 0, 5));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 271, 0, 255));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 256, 0, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 255, 0, 255));
      send_request(make_req(MODE_UNUSED, '1, '1, '1, '1, '1, '1, '1, -1, -1, 255));
      send_request(make_req(sdr_pkg::MODE_CLEAR, PX, PX, PX, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 255, 0, 255));
      send_request(make_req(sdr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3, 0, 20));
      // crossed edges draw nothing
      send_request(make_req(sdr_pkg::MODE_FILL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 2, 0));
      // top below the slice: untouched
      send_request(make_req(sdr_pkg::MODE_FILL, PX, PX, PX, PX, PX, PX, PX, 271, -16, 0));
      // wholly above the slice, forward and with a negative row count
      send_request(make_req(sdr_pkg::MODE_FILL, PX, 32'h0020_0000, sdr_pkg::DEPTH_ONE, PX, -PX,
                            32'h0000_4000, 0, -16, -1, 0));
      send_request(make_req(sdr_pkg::MODE_FILL, PX, 32'h0020_0000, sdr_pkg::DEPTH_ONE, PX, -PX,
                            32'h0000_4000, 0, -3, -10, 0));

      // Random transactions over a series of buffer widths and slices
      run_phase(256, 0, 256, 60);
      run_phase(16, 0, 256, 60);
      run_phase(64, 100, 140, 60);
      run_phase(256, 248, 256, 50);
      run_phase(32, 0, 0, 40);
      run_phase(128, 60, 20, 30);
      run_phase(256, 256, 256, 30);
      run_phase(16, 200, 256, 40);
      run_phase(256, 0, 256, 30);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (depth_sb.mismatches == 0)
         $display("span_depth_rasterizer_tb: PASS");
      else
         $display("span_depth_rasterizer_tb: FAIL");
      $finish;
   end

endmodule
